// File: rtl/core/ssp_pkg.sv
// shared types and constants for the single-source shortest path block
// no dependencies; imported by single_source_shortest_paths_top
`default_nettype none
package ssp_pkg;
	localparam int MaxVertices = 64;
	localparam int VertBits    = $clog2(MaxVertices);
	localparam int EdgeAddrBits = 2 * VertBits;
	localparam int EdgeDepth   = MaxVertices * MaxVertices;
	localparam int CountBits   = VertBits + 1;
	localparam int WeightBits  = 16;
	localparam int AddrBits    = 3;
	localparam logic [WeightBits-1:0] InfDist = 16'hFFFF;
	localparam logic [CountBits-1:0] CountReset = CountBits'(MaxVertices);

	typedef enum logic [1:0] {
		CMD_ADD   = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_RUN   = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic {
		REG_VCOUNT = 1'b0,
		REG_SOURCE = 1'b1
	} reg_t;

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_ADD_RD,
		S_ADD_WR,
		S_INIT,
		S_SRC,
		S_REL_RD,
		S_REL_WR,
		S_EM_RD,
		S_EM_LD,
		S_EM_WAIT
	} state_t;
endpackage
`default_nettype wire

// File: rtl/core/ssp_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module ssp_ram #(
	parameter int Width = 16,
	parameter int Depth = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: rtl/core/single_source_shortest_paths_top.sv
// dense-graph dijkstra: edge store, distance and parent tables, emit sequencer
// depends on ssp_pkg and ssp_ram
// add edge: read then conditional write of the edge store; clear: sweep of the 4096-entry edge store
// run: table init over n vertices and seeding of the source, then one relax pass over
// all n vertices per settled vertex (at most n passes), then a read, load and wait for
// each result, held until result_ready
// one command at a time; cmd_ready is low while a command is in progress
// reset: vertex_count 64, source 0, then a clearing pass over the 4096-entry edge store
`default_nettype none
module single_source_shortest_paths_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [ssp_pkg::AddrBits-1:0]      paddr,
	input  wire logic [31:0]                       pwdata,
	output logic      [31:0]                       prdata,
	output logic                                   pready,
	input  wire logic                              cmd_valid,
	output logic                                   cmd_ready,
	input  wire logic [1:0]                        cmd,
	input  wire logic [ssp_pkg::VertBits-1:0]      from_vertex,
	input  wire logic [ssp_pkg::VertBits-1:0]      to_vertex,
	input  wire logic [ssp_pkg::WeightBits-1:0]    edge_weight,
	output logic                                   result_valid,
	input  wire logic                              result_ready,
	output logic      [ssp_pkg::VertBits-1:0]      vertex,
	output logic      [ssp_pkg::WeightBits-1:0]    distance,
	output logic      [ssp_pkg::VertBits-1:0]      parent,
	output logic                                   reachable,
	output logic                                   last
);
	import ssp_pkg::*;

	state_t state_q, state_d;

	logic [CountBits-1:0]    vcount_q;
	logic [VertBits-1:0]     source_q;
	logic [CountBits-1:0]    n_q;
	logic [VertBits-1:0]     src_q;
	logic [EdgeAddrBits-1:0] clr_q;
	logic [VertBits-1:0]     v_q, k_q, bestk_q, from_q, to_q;
	logic [WeightBits-1:0]   dk_q, best_q, w_q;
	logic [MaxVertices-1:0]  settled_q;
	logic                    out_valid_q;
	logic [VertBits-1:0]     out_vertex_q, out_parent_q;
	logic [WeightBits-1:0]   out_dist_q;
	logic                    out_reach_q, out_last_q;

	logic                    edge_we, dist_we, pred_we;
	logic [EdgeAddrBits-1:0] edge_waddr, edge_raddr;
	logic [WeightBits:0]     edge_wdata, edge_rdata;
	logic [VertBits-1:0]     dist_waddr;
	logic [WeightBits-1:0]   dist_wdata, dist_rdata;
	logic [VertBits-1:0]     pred_wdata, pred_rdata;

	logic                    cmd_fire, cfg_write, v_last, src_in;
	logic [CountBits-1:0]    n_clamped;
	logic [WeightBits:0]     sum;
	logic [WeightBits-1:0]   sum_sat, new_dist, best_d;
	logic [VertBits-1:0]     bestk_d;
	logic                    relax;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign cmd_ready = (state_q == S_IDLE);
	assign cmd_fire  = cmd_valid && cmd_ready;

	always_comb begin
		prdata = '0;
		if (reg_t'(paddr[2]) == REG_VCOUNT) begin
			prdata[CountBits-1:0] = vcount_q;
		end else begin
			prdata[VertBits-1:0] = source_q;
		end
	end

	// count of zero acts as one, counts past the store size saturate
	always_comb begin
		n_clamped = vcount_q;
		if (vcount_q == '0) begin
			n_clamped = CountBits'(1);
		end else if (vcount_q > CountReset) begin
			n_clamped = CountReset;
		end
	end

	assign v_last = ({1'b0, v_q} + CountBits'(1)) == n_q;
	assign src_in = {1'b0, src_q} < n_q;

	// shared relax unit: saturating add, compare, running minimum
	assign sum     = {1'b0, dk_q} + {1'b0, edge_rdata[WeightBits-1:0]};
	assign sum_sat = sum[WeightBits] ? InfDist : sum[WeightBits-1:0];
	assign relax   = !settled_q[v_q] && edge_rdata[WeightBits] && (sum_sat < dist_rdata);
	assign new_dist = relax ? sum_sat : dist_rdata;

	always_comb begin
		best_d  = best_q;
		bestk_d = bestk_q;
		if (!settled_q[v_q] && new_dist < best_q) begin
			best_d  = new_dist;
			bestk_d = v_q;
		end
	end

	always_comb begin
		state_d    = state_q;
		edge_we    = 1'b0;
		edge_waddr = {from_q, to_q};
		edge_wdata = {1'b1, w_q};
		edge_raddr = {k_q, v_q};
		dist_we    = 1'b0;
		pred_we    = 1'b0;
		dist_waddr = v_q;
		dist_wdata = new_dist;
		pred_wdata = k_q;
		case (state_q)
			S_CLR: begin
				edge_we    = 1'b1;
				edge_waddr = clr_q;
				edge_wdata = '0;
				if (clr_q == '1) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (cmd_valid) begin
					case (cmd_t'(cmd))
						CMD_ADD:   state_d = S_ADD_RD;
						CMD_CLEAR: state_d = S_CLR;
						CMD_RUN:   state_d = S_INIT;
						default:   state_d = S_IDLE;
					endcase
				end
			end
			S_ADD_RD: begin
				edge_raddr = {from_q, to_q};
				state_d    = S_ADD_WR;
			end
			S_ADD_WR: begin
				edge_we = !edge_rdata[WeightBits] || (w_q < edge_rdata[WeightBits-1:0]);
				state_d = S_IDLE;
			end
			S_INIT: begin
				dist_we    = 1'b1;
				pred_we    = 1'b1;
				dist_wdata = InfDist;
				pred_wdata = '0;
				if (v_last) state_d = S_SRC;
			end
			S_SRC: begin
				dist_waddr = src_q;
				dist_wdata = '0;
				pred_wdata = src_q;
				dist_we    = src_in;
				pred_we    = src_in;
				state_d    = src_in ? S_REL_RD : S_EM_RD;
			end
			S_REL_RD: state_d = S_REL_WR;
			S_REL_WR: begin
				dist_we = relax;
				pred_we = relax;
				if (v_last) begin
					state_d = (best_d != InfDist) ? S_REL_RD : S_EM_RD;
				end else begin
					state_d = S_REL_RD;
				end
			end
			S_EM_RD: state_d = S_EM_LD;
			S_EM_LD: state_d = S_EM_WAIT;
			S_EM_WAIT: begin
				if (result_ready) state_d = v_last ? S_IDLE : S_EM_RD;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q    <= CountReset;
			source_q    <= '0;
			clr_q       <= '0;
			settled_q   <= '0;
			out_valid_q <= 1'b0;
			v_q         <= '0;
		end else begin
			if (cfg_write) begin
				if (reg_t'(paddr[2]) == REG_VCOUNT) begin
					vcount_q <= pwdata[CountBits-1:0];
				end else begin
					source_q <= pwdata[VertBits-1:0];
				end
			end
			case (state_q)
				S_CLR: clr_q <= clr_q + EdgeAddrBits'(1);
				S_IDLE: begin
					clr_q <= '0;
					v_q   <= '0;
					if (cmd_fire && cmd_t'(cmd) == CMD_RUN) settled_q <= '0;
				end
				S_INIT: v_q <= v_last ? '0 : v_q + VertBits'(1);
				S_SRC: begin
					v_q <= '0;
					if (src_in) settled_q[src_q] <= 1'b1;
				end
				S_REL_WR: begin
					if (v_last) begin
						v_q <= '0;
						if (best_d != InfDist) settled_q[bestk_d] <= 1'b1;
					end else begin
						v_q <= v_q + VertBits'(1);
					end
				end
				S_EM_LD: out_valid_q <= 1'b1;
				S_EM_WAIT: begin
					if (result_ready) begin
						out_valid_q <= 1'b0;
						v_q <= v_q + VertBits'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			from_q <= from_vertex;
			to_q   <= to_vertex;
			w_q    <= edge_weight;
			n_q    <= n_clamped;
			src_q  <= source_q;
		end
		if (state_q == S_SRC) begin
			k_q    <= src_q;
			dk_q   <= '0;
			best_q <= InfDist;
		end
		if (state_q == S_REL_WR) begin
			if (v_last) begin
				k_q    <= bestk_d;
				dk_q   <= best_d;
				best_q <= InfDist;
			end else begin
				best_q  <= best_d;
				bestk_q <= bestk_d;
			end
		end
		if (state_q == S_EM_LD) begin
			out_vertex_q <= v_q;
			out_dist_q   <= dist_rdata;
			out_parent_q <= pred_rdata;
			out_reach_q  <= dist_rdata != InfDist;
			out_last_q   <= v_last;
		end
	end

	assign result_valid = out_valid_q;
	assign vertex       = out_vertex_q;
	assign distance     = out_dist_q;
	assign parent       = out_parent_q;
	assign reachable    = out_reach_q;
	assign last         = out_last_q;

	// bit above the weight marks a present edge
	ssp_ram #(.Width(WeightBits + 1), .Depth(EdgeDepth)) u_edge_ram (
		.clk   (clk),
		.we    (edge_we),
		.waddr (edge_waddr),
		.wdata (edge_wdata),
		.raddr (edge_raddr),
		.rdata (edge_rdata)
	);

	ssp_ram #(.Width(WeightBits), .Depth(MaxVertices)) u_dist_ram (
		.clk   (clk),
		.we    (dist_we),
		.waddr (dist_waddr),
		.wdata (dist_wdata),
		.raddr (v_q),
		.rdata (dist_rdata)
	);

	ssp_ram #(.Width(VertBits), .Depth(MaxVertices)) u_pred_ram (
		.clk   (clk),
		.we    (pred_we),
		.waddr (dist_waddr),
		.wdata (pred_wdata),
		.raddr (v_q),
		.rdata (pred_rdata)
	);
endmodule
`default_nettype wire
